>>> rtl/core/assert_macros.svh
// Assertion macros for the checker module of the core.
// No dependencies; take in with `include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while dis is high.
`define CTFM_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("ctfm assertion failed");

// Next-cycle implication, switched off while dis is high.
`define CTFM_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("ctfm assertion failed");

`endif

>>> rtl/core/ctfm_pkg.sv
// Shared types and constants of the complex tensor multiply core.
// No dependencies; every module of the core imports it.
package ctfm_pkg;

  localparam int FIELD_W     = 64;
  localparam int HALF_W      = 32;
  localparam int N_IN_FIELDS = 9;
  localparam int N_COMP      = 3;
  localparam int N_TERMS     = N_COMP * N_COMP;
  localparam int IN_W        = N_IN_FIELDS * FIELD_W;
  localparam int OUT_W       = N_COMP * FIELD_W;

  // Pipeline stage positions
  localparam int N_STAGES = 5;
  localparam int STG_OPS  = 0;
  localparam int STG_MUL  = 1;
  localparam int STG_TERM = 2;
  localparam int STG_SUM  = 3;
  localparam int STG_OUT  = 4;

  typedef enum logic {
    TENSOR_SYM  = 1'b0,
    TENSOR_ANTI = 1'b1
  } tensor_mode_t;

  // Load enables of the two accumulation stages
  typedef struct packed {
    logic term;
    logic sum;
  } ctfm_sum_en_t;

endpackage

>>> rtl/core/ctfm_opsel.sv
// Operand stage: unpacks the tensor and vector parts of one request and
// forms the nine signed tensor operands for the current mode. Uses ctfm_pkg.
module ctfm_opsel import ctfm_pkg::*; #(
  parameter int PART_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  tensor_mode_t                  mode,
  input  logic [IN_W-1:0]               tdata,
  output logic signed [PART_WIDTH:0]    n_re [N_TERMS],
  output logic signed [PART_WIDTH:0]    n_im [N_TERMS],
  output logic signed [PART_WIDTH-1:0]  m_re [N_COMP],
  output logic signed [PART_WIDTH-1:0]  m_im [N_COMP]
);

  localparam int OP_W   = PART_WIDTH + 1;
  localparam int FLD_MX = 6;

  typedef enum logic [1:0] {
    ANTI_ZERO,
    ANTI_POS,
    ANTI_NEG
  } anti_t;

  // Tensor component feeding each term, row-major over the result
  localparam int TERM_N [N_TERMS] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
  // Sign of each term in antisymmetric mode
  localparam anti_t TERM_ANTI [N_TERMS] = '{ANTI_ZERO, ANTI_POS,  ANTI_POS,
                                            ANTI_NEG,  ANTI_ZERO, ANTI_POS,
                                            ANTI_NEG,  ANTI_NEG,  ANTI_ZERO};

  logic signed [PART_WIDTH-1:0] f_re [N_IN_FIELDS];
  logic signed [PART_WIDTH-1:0] f_im [N_IN_FIELDS];
  logic signed [OP_W-1:0]       n_re_nxt [N_TERMS];
  logic signed [OP_W-1:0]       n_im_nxt [N_TERMS];
  logic signed [OP_W-1:0]       n_re_r   [N_TERMS];
  logic signed [OP_W-1:0]       n_im_r   [N_TERMS];
  logic signed [PART_WIDTH-1:0] m_re_r   [N_COMP];
  logic signed [PART_WIDTH-1:0] m_im_r   [N_COMP];

  // Take the low part bits of each half; upper half bits are ignored
  for (genvar f = 0; f < N_IN_FIELDS; f++) begin : g_unpack
    assign f_re[f] = tdata[f*FIELD_W + HALF_W +: PART_WIDTH];
    assign f_im[f] = tdata[f*FIELD_W +: PART_WIDTH];
  end

  // Select, zero or negate the tensor operand of each term
  for (genvar t = 0; t < N_TERMS; t++) begin : g_term
    logic signed [OP_W-1:0] nr;
    logic signed [OP_W-1:0] ni;
    assign nr = OP_W'(f_re[TERM_N[t]]);
    assign ni = OP_W'(f_im[TERM_N[t]]);

    always_comb begin
      n_re_nxt[t] = nr;
      n_im_nxt[t] = ni;
      if (mode == TENSOR_ANTI) begin
        case (TERM_ANTI[t])
          ANTI_ZERO: begin
            n_re_nxt[t] = '0;
            n_im_nxt[t] = '0;
          end
          ANTI_NEG: begin
            n_re_nxt[t] = -nr;
            n_im_nxt[t] = -ni;
          end
          default: begin
            n_re_nxt[t] = nr;
            n_im_nxt[t] = ni;
          end
        endcase
      end
    end
  end

  // Hold operands while the next stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      n_re_r <= n_re_nxt;
      n_im_r <= n_im_nxt;
      for (int k = 0; k < N_COMP; k++) begin
        m_re_r[k] <= f_re[FLD_MX + k];
        m_im_r[k] <= f_im[FLD_MX + k];
      end
    end
  end

  assign n_re = n_re_r;
  assign n_im = n_im_r;
  assign m_re = m_re_r;
  assign m_im = m_im_r;

endmodule

>>> rtl/core/ctfm_cmul.sv
// Product stage for one term: the four real partial products of a
// complex tensor operand and a complex vector part. Uses ctfm_pkg.
module ctfm_cmul import ctfm_pkg::*; #(
  parameter int PART_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [PART_WIDTH:0]      n_re,
  input  logic signed [PART_WIDTH:0]      n_im,
  input  logic signed [PART_WIDTH-1:0]    m_re,
  input  logic signed [PART_WIDTH-1:0]    m_im,
  output logic signed [2*PART_WIDTH:0]    rr,
  output logic signed [2*PART_WIDTH:0]    ii,
  output logic signed [2*PART_WIDTH:0]    ir,
  output logic signed [2*PART_WIDTH:0]    ri
);

  localparam int P_W = 2 * PART_WIDTH + 1;

  logic signed [P_W-1:0] rr_r, ii_r, ir_r, ri_r;

  // Register each product; hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      rr_r <= P_W'(n_re) * P_W'(m_re);
      ii_r <= P_W'(n_im) * P_W'(m_im);
      ir_r <= P_W'(n_im) * P_W'(m_re);
      ri_r <= P_W'(n_re) * P_W'(m_im);
    end
  end

  assign rr = rr_r;
  assign ii = ii_r;
  assign ir = ir_r;
  assign ri = ri_r;

endmodule

>>> rtl/core/ctfm_sum.sv
// Accumulation for one result component: combines partial products into
// complex terms, then adds the three terms exactly. Uses ctfm_pkg.
module ctfm_sum import ctfm_pkg::*; #(
  parameter int PART_WIDTH = 32
) (
  input  logic                            clk,
  input  ctfm_sum_en_t                    en,
  input  logic signed [2*PART_WIDTH:0]    rr [N_COMP],
  input  logic signed [2*PART_WIDTH:0]    ii [N_COMP],
  input  logic signed [2*PART_WIDTH:0]    ir [N_COMP],
  input  logic signed [2*PART_WIDTH:0]    ri [N_COMP],
  output logic signed [2*PART_WIDTH+3:0]  s_re,
  output logic signed [2*PART_WIDTH+3:0]  s_im
);

  localparam int T_W = 2 * PART_WIDTH + 2;
  localparam int S_W = 2 * PART_WIDTH + 4;

  logic signed [T_W-1:0] t_re_r [N_COMP];
  logic signed [T_W-1:0] t_im_r [N_COMP];
  logic signed [S_W-1:0] s_re_r, s_im_r;

  // Complex product of each term
  always_ff @(posedge clk) begin
    if (en.term) begin
      for (int k = 0; k < N_COMP; k++) begin
        t_re_r[k] <= T_W'(rr[k]) - T_W'(ii[k]);
        t_im_r[k] <= T_W'(ir[k]) + T_W'(ri[k]);
      end
    end
  end

  // Sum the three terms of the row
  always_ff @(posedge clk) begin
    if (en.sum) begin
      s_re_r <= S_W'(t_re_r[0]) + S_W'(t_re_r[1]) + S_W'(t_re_r[2]);
      s_im_r <= S_W'(t_im_r[0]) + S_W'(t_im_r[1]) + S_W'(t_im_r[2]);
    end
  end

  assign s_re = s_re_r;
  assign s_im = s_im_r;

endmodule

>>> rtl/core/ctfm_sat.sv
// Output stage for one result component: drops the fraction bits of both
// exact sums, saturates them and packs real-high, imaginary-low. Uses ctfm_pkg.
module ctfm_sat import ctfm_pkg::*; #(
  parameter int PART_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [2*PART_WIDTH+3:0]  s_re,
  input  logic signed [2*PART_WIDTH+3:0]  s_im,
  output logic [FIELD_W-1:0]              h
);

  localparam int S_W = 2 * PART_WIDTH + 4;
  localparam logic signed [S_W-1:0] MAXV = {{(S_W-PART_WIDTH+1){1'b0}},
                                            {(PART_WIDTH-1){1'b1}}};
  localparam logic signed [S_W-1:0] MINV = {{(S_W-PART_WIDTH+1){1'b1}},
                                            {(PART_WIDTH-1){1'b0}}};

  logic [FIELD_W-1:0] h_r;

  // Floor shift, clamp to the part range, sign-extend to a half
  function automatic logic [HALF_W-1:0] sat_part(input logic signed [S_W-1:0] s);
    logic signed [S_W-1:0]        sh;
    logic signed [PART_WIDTH-1:0] p;
    sh = s >>> FRAC_BITS;
    if (sh > MAXV) begin
      p = MAXV[PART_WIDTH-1:0];
    end else if (sh < MINV) begin
      p = MINV[PART_WIDTH-1:0];
    end else begin
      p = sh[PART_WIDTH-1:0];
    end
    return HALF_W'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= {sat_part(s_re), sat_part(s_im)};
    end
  end

  assign h = h_r;

endmodule

>>> rtl/core/complex_tensor_field_multiply_core.sv
// Top level of the complex 3x3 tensor times complex 3-vector core.
// Depends on ctfm_pkg, ctfm_opsel, ctfm_cmul, ctfm_sum and ctfm_sat.
//
// One request carries a complex tensor (six unique components) and a complex
// vector; the result is H = N*M. A new request is accepted every cycle while
// the output is taken. The pipeline has five register stages: operand select,
// 36 parallel multipliers, term combine, row sum, shift-and-saturate. A stall on
// the output side holds every stage in place; a stage that holds no request
// still loads, so bubbles close up. cfg_wdata selects symmetric (0) or
// antisymmetric (1) tensor mode; the user must write it only while the
// pipeline is empty; the core itself does not enforce this.
module complex_tensor_field_multiply_core import ctfm_pkg::*; #(
  parameter int FRAC_BITS  = 24,
  parameter int PART_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wen,
  input  logic             cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // n_xx, n_xy, n_xz, n_yy, n_yz, n_zz, m_x, m_y, m_z (64 bits each, from bit 0)
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // h_x, h_y, h_z (64 bits each, from bit 0)
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int OP_W = PART_WIDTH + 1;
  localparam int P_W  = 2 * PART_WIDTH + 1;
  localparam int S_W  = 2 * PART_WIDTH + 4;

  tensor_mode_t          mode_r;
  logic [N_STAGES-1:0]   en;
  logic [N_STAGES-1:0]   valid_r, valid_nxt;
  logic [N_STAGES-1:0]   last_r;

  logic signed [OP_W-1:0]       n_re [N_TERMS];
  logic signed [OP_W-1:0]       n_im [N_TERMS];
  logic signed [PART_WIDTH-1:0] m_re [N_COMP];
  logic signed [PART_WIDTH-1:0] m_im [N_COMP];
  logic signed [P_W-1:0]        p_rr [N_TERMS];
  logic signed [P_W-1:0]        p_ii [N_TERMS];
  logic signed [P_W-1:0]        p_ir [N_TERMS];
  logic signed [P_W-1:0]        p_ri [N_TERMS];
  logic signed [S_W-1:0]        s_re [N_COMP];
  logic signed [S_W-1:0]        s_im [N_COMP];
  ctfm_sum_en_t                 sum_en;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= TENSOR_SYM;
    end else if (cfg_wen) begin
      mode_r <= tensor_mode_t'(cfg_wdata);
    end
  end

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[STG_OUT] = !valid_r[STG_OUT] || out_tready;
    for (int s = STG_OUT - 1; s >= 0; s--) begin
      en[s] = !valid_r[s] || en[s+1];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    valid_nxt[STG_OPS] = en[STG_OPS] ? in_tvalid : valid_r[STG_OPS];
    for (int s = 1; s < N_STAGES; s++) begin
      valid_nxt[s] = en[s] ? valid_r[s-1] : valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Carry the frame marker alongside
  always_ff @(posedge clk) begin
    if (en[STG_OPS]) begin
      last_r[STG_OPS] <= in_tlast;
    end
    for (int s = 1; s < N_STAGES; s++) begin
      if (en[s]) begin
        last_r[s] <= last_r[s-1];
      end
    end
  end

  ctfm_opsel #(
    .PART_WIDTH (PART_WIDTH)
  ) u_opsel (
    .clk   (clk),
    .en    (en[STG_OPS]),
    .mode  (mode_r),
    .tdata (in_tdata),
    .n_re  (n_re),
    .n_im  (n_im),
    .m_re  (m_re),
    .m_im  (m_im)
  );

  for (genvar t = 0; t < N_TERMS; t++) begin : g_mul
    ctfm_cmul #(
      .PART_WIDTH (PART_WIDTH)
    ) u_cmul (
      .clk  (clk),
      .en   (en[STG_MUL]),
      .n_re (n_re[t]),
      .n_im (n_im[t]),
      .m_re (m_re[t % N_COMP]),
      .m_im (m_im[t % N_COMP]),
      .rr   (p_rr[t]),
      .ii   (p_ii[t]),
      .ir   (p_ir[t]),
      .ri   (p_ri[t])
    );
  end

  assign sum_en.term = en[STG_TERM];
  assign sum_en.sum  = en[STG_SUM];

  for (genvar c = 0; c < N_COMP; c++) begin : g_row
    logic signed [P_W-1:0] c_rr [N_COMP];
    logic signed [P_W-1:0] c_ii [N_COMP];
    logic signed [P_W-1:0] c_ir [N_COMP];
    logic signed [P_W-1:0] c_ri [N_COMP];

    for (genvar k = 0; k < N_COMP; k++) begin : g_pick
      assign c_rr[k] = p_rr[c*N_COMP + k];
      assign c_ii[k] = p_ii[c*N_COMP + k];
      assign c_ir[k] = p_ir[c*N_COMP + k];
      assign c_ri[k] = p_ri[c*N_COMP + k];
    end

    ctfm_sum #(
      .PART_WIDTH (PART_WIDTH)
    ) u_sum (
      .clk  (clk),
      .en   (sum_en),
      .rr   (c_rr),
      .ii   (c_ii),
      .ir   (c_ir),
      .ri   (c_ri),
      .s_re (s_re[c]),
      .s_im (s_im[c])
    );

    ctfm_sat #(
      .PART_WIDTH (PART_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_sat (
      .clk  (clk),
      .en   (en[STG_OUT]),
      .s_re (s_re[c]),
      .s_im (s_im[c]),
      .h    (out_tdata[c*FIELD_W +: FIELD_W])
    );
  end

  assign in_tready  = en[STG_OPS];
  assign out_tvalid = valid_r[STG_OUT];
  assign out_tlast  = last_r[STG_OUT];

endmodule

>>> rtl/core/ctfm_checker.sv
// Port-level checker for the tensor multiply core, bound to the top level.
// Depends on assert_macros.svh and ctfm_pkg.
`include "assert_macros.svh"

module ctfm_checker import ctfm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tlast,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  // Hold a refused result unchanged
  `CTFM_ASSERT_NXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))

  // Drop everything in flight on reset
  `CTFM_ASSERT_NXT(a_rst_empty, clk, 1'b0, !rst_n, !out_tvalid)

  // With the output open throughout, an accepted request leaves at the output
  `CTFM_ASSERT_IMP(a_flow_latency, clk, !rst_n,
                   $past(in_tvalid && in_tready, 5) && $past(rst_n, 5) && $past(rst_n, 4)
                   && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
                   && $past(out_tready, 4) && $past(out_tready, 3)
                   && $past(out_tready, 2) && $past(out_tready, 1),
                   out_tvalid)

  // The frame marker leaves with its own request
  `CTFM_ASSERT_IMP(a_flow_last, clk, !rst_n,
                   $past(in_tvalid && in_tready, 5) && $past(rst_n, 5) && $past(rst_n, 4)
                   && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
                   && $past(out_tready, 4) && $past(out_tready, 3)
                   && $past(out_tready, 2) && $past(out_tready, 1),
                   out_tlast == $past(in_tlast, 5))

endmodule

bind complex_tensor_field_multiply_core ctfm_checker u_ctfm_checker (.*);
